[rtl/core/edf_pkg.sv]
// Shared types and constants for the escaped packet deframer.
// Depends on nothing; imported by every module of the block.
`default_nettype none

package edf_pkg;

   // Line codes with special meaning.
   localparam logic [7:0] ESCAPE_CODE = 8'hFE;
   localparam logic [7:0] END_CODE    = 8'hFF;

   // Fixed field widths.
   localparam int BYTE_W = 8;
   localparam int LEN_W  = 7;

   // Depth of the queue between the front and the back.
   localparam int QUEUE_DEPTH = 2;

   // One command from the front to the back: store a decoded byte or end a packet.
   typedef struct packed {
      logic              is_end;
      logic [BYTE_W-1:0] data;
   } cmd_type;

   // Push side of the queue.
   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } push_type;

   // Pop side of the queue as seen by the back.
   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } head_type;

endpackage

`default_nettype wire

[rtl/core/edf_front.sv]
// Front part of the deframer: accepts line bytes, tracks the escape flag and
// turns each byte but an escape code into a command for the queue. Depends on edf_pkg.
`default_nettype none

module edf_front
   import edf_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [BYTE_W-1:0] req_rx_byte,
   input  wire logic              queue_full,
   output push_type               push
);

   logic escape_ff;
   logic escape_in;
   logic accept;
   logic [BYTE_W-1:0] decoded;

   // A beat is taken whenever the queue has room, escapes included.
   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;

   // Undo the escape on the byte that follows an escape code.
   always_comb begin
      decoded = req_rx_byte;
      if (escape_ff) begin
         if (req_rx_byte == 8'h00) begin
            decoded = ESCAPE_CODE;
         end else if (req_rx_byte == 8'h01) begin
            decoded = END_CODE;
         end
      end
   end

   // Escape codes are dropped; everything else becomes a command.
   always_comb begin
      push.valid      = accept && (req_rx_byte != ESCAPE_CODE);
      push.cmd.is_end = (req_rx_byte == END_CODE);
      push.cmd.data   = decoded;
   end

   // The flag is set by an escape, kept by a terminator, cleared by any other byte.
   always_comb begin
      escape_in = escape_ff;
      if (accept) begin
         if (req_rx_byte == ESCAPE_CODE) begin
            escape_in = 1'b1;
         end else if (req_rx_byte != END_CODE) begin
            escape_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         escape_ff <= 1'b0;
      end else begin
         escape_ff <= escape_in;
      end
   end

endmodule

`default_nettype wire

[rtl/core/edf_queue.sv]
// Small command queue that decouples the front from the back.
// Depends on edf_pkg for the command type and depth.
`default_nettype none

module edf_queue
   import edf_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire push_type push,
   output logic          full,
   output head_type      head,
   input  wire logic     pop
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type          entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full       = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.cmd   = entry_ff[rd_ptr_ff];

   assign do_push = push.valid && !full;
   assign do_pop  = pop && head.valid;

   // Pointer and occupancy update with wrap at the queue depth.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push.cmd;
      end
   end

endmodule

`default_nettype wire

[rtl/core/edf_back.sv]
// Back part of the deframer: stores packet bytes in a local memory and drains
// them as result beats on a terminator. Depends on edf_pkg.
`default_nettype none

module edf_back
   import edf_pkg::*;
#(
   parameter int PACKET_BYTES = 64
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire head_type          head,
   output logic                   pop,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [BYTE_W-1:0]      rsp_out_byte,
   output logic                   rsp_is_last,
   output logic                   rsp_empty_packet,
   output logic [LEN_W-1:0]       rsp_packet_length
);

   localparam int AW = (PACKET_BYTES > 1) ? $clog2(PACKET_BYTES) : 1;
   localparam int CW = $clog2(PACKET_BYTES + 1);

   typedef enum logic [1:0] {
      ST_IDLE  = 2'b01,
      ST_DRAIN = 2'b10
   } state_type;

   state_type         state_ff, state_in;
   logic [BYTE_W-1:0] store_mem [PACKET_BYTES];
   logic [CW-1:0]     fill_ff, fill_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [AW-1:0]     idx_ff, idx_in;
   logic [CW-1:0]     idx_next;
   logic              out_free;
   logic              store_we;
   logic              load_mem;
   logic              load_empty;
   logic              drain_last;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] rsp_out_byte_ff;
   logic              rsp_is_last_ff;
   logic              rsp_empty_packet_ff;
   logic [LEN_W-1:0]  rsp_packet_length_ff;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign idx_next   = CW'(idx_ff) + CW'(1);
   assign drain_last = (idx_next == count_ff);

   // Sequencer: consume commands while idle, read the store out while draining.
   always_comb begin
      state_in   = state_ff;
      fill_in    = fill_ff;
      count_in   = count_ff;
      idx_in     = idx_ff;
      pop        = 1'b0;
      store_we   = 1'b0;
      load_mem   = 1'b0;
      load_empty = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (head.valid) begin
               if (!head.cmd.is_end) begin
                  pop = 1'b1;
                  if (fill_ff < CW'(PACKET_BYTES)) begin
                     store_we = 1'b1;
                     fill_in  = fill_ff + CW'(1);
                  end
               end else if (fill_ff == '0) begin
                  if (out_free) begin
                     pop        = 1'b1;
                     load_empty = 1'b1;
                  end
               end else begin
                  pop      = 1'b1;
                  count_in = fill_ff;
                  fill_in  = '0;
                  idx_in   = '0;
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            if (out_free) begin
               load_mem = 1'b1;
               idx_in   = AW'(idx_next);
               if (drain_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output register holds a beat until it is taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_mem || load_empty) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      count_ff <= count_in;
      idx_ff   <= idx_in;
   end

   // Packet store: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (store_we) begin
         store_mem[fill_ff[AW-1:0]] <= head.cmd.data;
      end
   end

   // Result payload; the memory read lands directly in the output byte.
   always_ff @(posedge clock) begin
      if (load_mem) begin
         rsp_out_byte_ff      <= store_mem[idx_ff];
         rsp_is_last_ff       <= drain_last;
         rsp_empty_packet_ff  <= 1'b0;
         rsp_packet_length_ff <= LEN_W'(count_ff);
      end else if (load_empty) begin
         rsp_out_byte_ff      <= '0;
         rsp_is_last_ff       <= 1'b1;
         rsp_empty_packet_ff  <= 1'b1;
         rsp_packet_length_ff <= '0;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_byte      = rsp_out_byte_ff;
   assign rsp_is_last       = rsp_is_last_ff;
   assign rsp_empty_packet  = rsp_empty_packet_ff;
   assign rsp_packet_length = rsp_packet_length_ff;

endmodule

`default_nettype wire

[rtl/core/escaped_packet_deframer.sv]
// Top level of the escaped packet deframer.
// Depends on edf_pkg, edf_front, edf_queue and edf_back.
//
// The block takes one line byte per beat and returns decoded packet bytes.
// Escape codes are removed and the byte after one is unescaped, stored bytes
// go into an on-chip store of PACKET_BYTES entries, and a terminator drains
// the store as one result beat per byte (the last one marked), or as a single
// empty-packet beat. While no packet drains and no result beat is stalled, a
// byte is taken every cycle. A terminator for a packet of n bytes holds the
// back while it is taken and while its beats leave, one per cycle, through
// the single read port of the store, and longer while rsp_stall holds a beat;
// the two-entry command queue keeps taking input meanwhile until it fills,
// after which req_stall stays high until the back takes commands again. Bytes
// past the store capacity are dropped. No clearing pass is needed after reset.
`default_nettype none

module escaped_packet_deframer
   import edf_pkg::*;
#(
   parameter int PACKET_BYTES = 64
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [BYTE_W-1:0] req_rx_byte,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [BYTE_W-1:0]      rsp_out_byte,
   output logic                   rsp_is_last,
   output logic                   rsp_empty_packet,
   output logic [LEN_W-1:0]       rsp_packet_length
);

   push_type push;
   head_type head;
   logic     queue_full;
   logic     pop;

   edf_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_rx_byte (req_rx_byte),
      .queue_full  (queue_full),
      .push        (push)
   );

   edf_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .full  (queue_full),
      .head  (head),
      .pop   (pop)
   );

   edf_back #(
      .PACKET_BYTES (PACKET_BYTES)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .head              (head),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_is_last       (rsp_is_last),
      .rsp_empty_packet  (rsp_empty_packet),
      .rsp_packet_length (rsp_packet_length)
   );

endmodule

`default_nettype wire

[rtl/core/edf_checker.sv]
// Port-level checks for the escaped packet deframer, with the bind that
// attaches them to the top level. Depends on edf_pkg.
`default_nettype none

module edf_checker
   import edf_pkg::*;
#(
   parameter int PACKET_BYTES = 64
) (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input wire logic [BYTE_W-1:0] rsp_out_byte,
   input wire logic              rsp_is_last,
   input wire logic              rsp_empty_packet,
   input wire logic [LEN_W-1:0]  rsp_packet_length
);

   // An empty-packet beat is a lone, zeroed, final beat.
   a_empty_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_empty_packet |->
         rsp_is_last && rsp_packet_length == '0 && rsp_out_byte == '0)
      else $error("empty packet beat has wrong shape");

   // A data beat carries a length between one and the store capacity.
   a_length_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_empty_packet |->
         rsp_packet_length != '0 && rsp_packet_length <= LEN_W'(PACKET_BYTES))
      else $error("packet length out of range");

   // Within a packet the next beat follows at once with the same length.
   a_drain_gapless: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_is_last |=>
         rsp_valid && !rsp_empty_packet && rsp_packet_length == $past(rsp_packet_length))
      else $error("packet drain broke or changed length");

   // A stalled result beat holds.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=>
         rsp_valid && $stable(rsp_out_byte) && $stable(rsp_is_last)
         && $stable(rsp_empty_packet) && $stable(rsp_packet_length))
      else $error("stalled result beat changed");

endmodule

bind escaped_packet_deframer edf_checker #(
   .PACKET_BYTES (PACKET_BYTES)
) u_edf_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_out_byte      (rsp_out_byte),
   .rsp_is_last       (rsp_is_last),
   .rsp_empty_packet  (rsp_empty_packet),
   .rsp_packet_length (rsp_packet_length)
);

`default_nettype wire
